// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Storage and field sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int ELEM_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 5;
  localparam int CNT_OUT_W   = 5;
  localparam int STATUS_W    = 2;
  localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Stream word layouts
  localparam int IN_FIELDS_W  = ELEM_W + PRIO_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ELEM_W + PRIO_W + STATUS_W + 2 + CNT_OUT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Reset value of the capacity limit
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  // Operation codes carried in tuser
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // apply the captured operation, load the result word
  } ctrl_cmd_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held sorted by descending priority.
// ----------------------------------------------------------------------------
// Each input word is an insert (tuser 0) or an extract of the head (tuser 1),
// and each gives one result word. Inserts land behind every entry of equal or
// higher priority, so ties leave in arrival order. Each word is captured,
// then executed: all entries compare against the new priority in parallel
// and shift by one place; a result waiting at the output holds off the next
// capture until the sink takes it. cfg_data sets the count
// at which the queue reports full (values above the depth act as the depth);
// write it only while the queue is idle. No clearing pass is needed after
// reset.
module sorted_priority_queue import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // element [31:0], priority [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func [0]: 0 insert, 1 extract
  input  logic [0:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // element [31:0], priority [47:32], status [49:48], is_empty [50],
  // is_full [51], entry_count [56:52]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

  // An accepted word shows a result once its execute state has loaded the result word
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted word gave no result");

  // No capture while the previous word is still executing
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("capture during execute");

  // Reported count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[56:52] <= CNT_OUT_W'(QUEUE_DEPTH)))
    else $error("count above depth");

  // Empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[50] == (out_tdata[56:52] == '0)))
    else $error("empty flag mismatch");

  // An error status never carries an extracted element
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[49:48] != ST_DONE) |-> (out_tdata[47:0] == '0))
    else $error("payload on error status");

endmodule

// ===== src/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts a word, runs the execute state, and keeps
// the result word valid until the sink takes it.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        // result slot is free by the execute cycle
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== src/spq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted entry registers with a compare per entry, count, capacity limit
// and the result register.
// ----------------------------------------------------------------------------
module spq_dpath import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Captured input word
  op_t                op_r;
  logic [ELEM_W-1:0]  elem_r;
  logic [PRIO_W-1:0]  prio_r;

  // Entries, head at index 0
  logic [ELEM_W-1:0]  ent_elem_r [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  ent_prio_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CFG_W-1:0]   cap_r;

  logic [OUT_DATA_W-1:0] out_r;

  logic [LIM_W-1:0]   lim;
  logic               full_now;
  logic               empty_now;
  logic               do_ins;
  logic               do_ext;
  logic [QUEUE_DEPTH-1:0] ge;
  status_t            status;
  logic [ELEM_W-1:0]  eout;
  logic [PRIO_W-1:0]  pout;
  logic               full_after;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_tuser[0]);
      elem_r <= in_tdata[ELEM_W-1:0];
      prio_r <= in_tdata[ELEM_W +: PRIO_W];
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // Effective limit, clamped to the depth
  always_comb begin
    if (LIM_W'(cap_r) > LIM_W'(QUEUE_DEPTH)) begin
      lim = LIM_W'(QUEUE_DEPTH);
    end else begin
      lim = LIM_W'(cap_r);
    end
  end

  assign full_now  = LIM_W'(cnt_r) >= lim;
  assign empty_now = (cnt_r == '0);
  assign do_ins    = (op_r == OP_INSERT) && !full_now;
  assign do_ext    = (op_r == OP_EXTRACT) && !empty_now;

  // Per-entry compare: held entry stays ahead of the new one
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
    assign ge[i] = (CNT_W'(i) < cnt_r) && ($signed(ent_prio_r[i]) >= $signed(prio_r));
  end

  // Entry update: insert opens a slot after the last ge entry, extract shifts up
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_ins && !ge[i]) begin
          if (i == 0) begin
            ent_elem_r[i] <= elem_r;
            ent_prio_r[i] <= prio_r;
          end else if (ge[(i > 0) ? i - 1 : 0]) begin
            ent_elem_r[i] <= elem_r;
            ent_prio_r[i] <= prio_r;
          end else begin
            ent_elem_r[i] <= ent_elem_r[(i > 0) ? i - 1 : 0];
            ent_prio_r[i] <= ent_prio_r[(i > 0) ? i - 1 : 0];
          end
        end else if (do_ext && (i < QUEUE_DEPTH - 1)) begin
          ent_elem_r[i] <= ent_elem_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          ent_prio_r[i] <= ent_prio_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Count and result fields
  always_comb begin
    cnt_nxt = cnt_r;
    status  = ST_DONE;
    eout    = '0;
    pout    = '0;
    if (op_r == OP_INSERT) begin
      if (full_now) begin
        status = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (empty_now) begin
        status = ST_EMPTY;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
        eout    = ent_elem_r[0];
        pout    = ent_prio_r[0];
      end
    end
  end

  assign full_after = LIM_W'(cnt_nxt) >= lim;

  // Count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= OUT_DATA_W'({CNT_OUT_W'(cnt_nxt), full_after, (cnt_nxt == '0),
                            status, pout, eout});
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== dv/spq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_result_checker
// Predicts and checks every result word of the sorted priority queue.
// ----------------------------------------------------------------------------
// Watches the input, config and result channels. It keeps its own sorted copy
// of the queue and of the capacity limit, updated on every accepted input and
// config word. Each accepted result word is checked field by field against
// the oldest predicted word.
// ----------------------------------------------------------------------------
module spq_result_checker import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    results_owed,
  output int                    mismatch_count
);

  localparam int MAX_PRINTS = 40;

  // Bit offsets inside the words
  localparam int PRIO_LSB   = ELEM_W;
  localparam int STATUS_LSB = PRIO_LSB + PRIO_W;
  localparam int EMPTY_BIT  = STATUS_LSB + STATUS_W;
  localparam int FULL_BIT   = EMPTY_BIT + 1;
  localparam int COUNT_LSB  = FULL_BIT + 1;

  typedef struct {
    logic [ELEM_W-1:0]        element;
    logic signed [PRIO_W-1:0] prio;
    status_t                  status;
    logic                     empty_flag;
    logic                     full_flag;
    logic [CNT_OUT_W-1:0]     count;
  } pq_result_t;

  // Shadow queue, head at index 0
  logic [ELEM_W-1:0]        held_elem [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
  int                       held_count;
  logic [CFG_W-1:0]         cap_limit;
  pq_result_t               pending_results [$];
  int                       result_no;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t ns: result word %0d, %s: got %0h, expected %0h",
               $time, result_no, what, got, want);
    end
  endtask

  // Applies one operation to the shadow queue and forms the result word
  task automatic apply_queue_op(input op_t op, input logic [ELEM_W-1:0] elem,
                                input logic signed [PRIO_W-1:0] prio,
                                output pq_result_t res);
    int lim;
    int slot;
    lim = (cap_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cap_limit);
    res.element = '0;
    res.prio    = '0;
    res.status  = ST_DONE;
    if (op == OP_INSERT) begin
      if (held_count >= lim) begin
        res.status = ST_FULL;
      end else begin
        // land behind every entry of equal or higher priority
        slot = 0;
        while (slot < held_count && held_prio[slot] >= prio) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_elem[i] = held_elem[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_elem[slot] = elem;
        held_prio[slot] = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.element = held_elem[0];
        res.prio    = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_elem[i-1] = held_elem[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.empty_flag = (held_count == 0);
    res.full_flag  = (held_count >= lim);
    res.count      = CNT_OUT_W'(held_count);
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    pq_result_t want;
    pq_result_t got;
    if (!rst_n) begin
      held_count = 0;
      cap_limit  = CAP_RESET;
      pending_results.delete();
      result_no      = 0;
      results_owed   = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_limit = cfg_data;

      if (in_tvalid && in_tready) begin
        apply_queue_op(op_t'(in_tuser[0]), in_tdata[ELEM_W-1:0],
                       in_tdata[PRIO_LSB +: PRIO_W], want);
        pending_results.push_back(want);
      end

      if (out_tvalid && out_tready) begin
        got.element    = out_tdata[ELEM_W-1:0];
        got.prio       = out_tdata[PRIO_LSB +: PRIO_W];
        got.status     = status_t'(out_tdata[STATUS_LSB +: STATUS_W]);
        got.empty_flag = out_tdata[EMPTY_BIT];
        got.full_flag  = out_tdata[FULL_BIT];
        got.count      = out_tdata[COUNT_LSB +: CNT_OUT_W];
        if (pending_results.size() == 0) begin
          report_mismatch("word with none expected", 64'(out_tdata), '0);
        end else begin
          want = pending_results.pop_front();
          if (got.element !== want.element)
            report_mismatch("element", 64'(got.element), 64'(want.element));
          if (got.prio !== want.prio)
            report_mismatch("priority", 64'(got.prio), 64'(want.prio));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.empty_flag !== want.empty_flag)
            report_mismatch("is_empty", 64'(got.empty_flag), 64'(want.empty_flag));
          if (got.full_flag !== want.full_flag)
            report_mismatch("is_full", 64'(got.full_flag), 64'(want.full_flag));
          if (got.count !== want.count)
            report_mismatch("entry_count", 64'(got.count), 64'(want.count));
        end
        result_no++;
      end

      results_owed = pending_results.size();
    end
  end

endmodule

// ===== dv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Stimulus and verdict for the sorted priority queue.
// ----------------------------------------------------------------------------
// A directed part covers empty extracts, extreme priorities, ties, a zero
// limit and a limit lowered below the count. Random segments follow, each
// under its own capacity limit, one of them above the depth, and insert mix,
// across three back-pressure phases. Checking is done by spq_result_checker.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam logic [PRIO_W-1:0] PRIO_MIN   = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam logic [PRIO_W-1:0] PRIO_MAX   = {1'b0, {(PRIO_W-1){1'b1}}};
  localparam int                TIMEOUT_NS = 1_000_000;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;   // element [31:0], priority [47:32]
  logic [0:0]            in_tuser;   // func [0]
  logic                  in_tvalid;
  logic                  in_tready;
  // element, priority, status, is_empty, is_full, entry_count from bit 0 up
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  int                    results_owed;
  int                    mismatch_count;
  int                    send_idle_pct;
  int                    recv_idle_pct;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  spq_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_data       (cfg_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #TIMEOUT_NS;
    $display("sorted_priority_queue test failed");
    $finish;
  end

  // Result side back-pressure, redrawn every cycle
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One input word, with random idle cycles ahead of it
  task automatic send_word(input op_t op, input logic [ELEM_W-1:0] elem,
                           input logic [PRIO_W-1:0] prio);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({prio, elem});
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every result word is back
  task automatic drain_queue();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_W-1:0] limit);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    op_t               op;
    logic [ELEM_W-1:0] elem;
    logic [PRIO_W-1:0] prio;
    logic [CFG_W-1:0]  limit;
    int                ins_pct;

    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    in_tvalid     = 1'b0;
    cfg_data      = '0;
    cfg_valid     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty extract, extreme priorities, a tie, drain in order
    send_word(OP_EXTRACT, '0, '0);
    send_word(OP_INSERT, 32'h0000_0000, PRIO_MIN);
    send_word(OP_INSERT, 32'hFFFF_FFFF, PRIO_MAX);
    send_word(OP_INSERT, 32'hA5A5_A5A5, 16'h0000);
    send_word(OP_INSERT, 32'h5A5A_5A5A, 16'h0000);
    send_word(OP_INSERT, 32'h1234_5678, 16'hFFFF);
    repeat (6) send_word(OP_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF);

    // Zero limit: always full, inserts refused
    drain_queue();
    cfg_write(5'd0);
    send_word(OP_INSERT, 32'hDEAD_BEEF, 16'h0001);
    send_word(OP_EXTRACT, '0, '0);

    // Small limit reached, then lowered below the count
    drain_queue();
    cfg_write(5'd2);
    send_word(OP_INSERT, 32'h0000_0001, 16'h0010);
    send_word(OP_INSERT, 32'h0000_0002, 16'h0020);
    send_word(OP_INSERT, 32'h0000_0003, 16'h0030);
    drain_queue();
    cfg_write(5'd1);
    send_word(OP_INSERT, 32'h0000_0004, 16'h0040);
    send_word(OP_EXTRACT, '0, '0);
    send_word(OP_EXTRACT, '0, '0);

    // Random segments under three back-pressure phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 7; seg++) begin
        case (seg)
          0:       limit = 5'd31;
          1:       limit = 5'd16;
          3:       limit = 5'd0;
          default: limit = CFG_W'($urandom_range(1, 20));
        endcase
        case ($urandom_range(2))
          0:       ins_pct = 80;
          1:       ins_pct = 50;
          default: ins_pct = 25;
        endcase
        if (seg == 0) ins_pct = 85;   // fill to the depth early
        drain_queue();
        cfg_write(limit);
        repeat ($urandom_range(30, 50)) begin
          op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
          // many near-zero priorities so ties are common
          case ($urandom_range(9))
            0:          prio = PRIO_MIN;
            1:          prio = PRIO_MAX;
            2, 3, 4, 5: prio = PRIO_W'($urandom_range(4)) - PRIO_W'(2);
            default:    prio = PRIO_W'($urandom);
          endcase
          case ($urandom_range(15))
            0:       elem = '0;
            1:       elem = '1;
            default: elem = ELEM_W'($urandom);
          endcase
          send_word(op, elem, prio);
        end
      end
    end

    drain_queue();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
